// ----- sv/icdf_pkg.sv -----
// ----------------------------------------------------------------------------
// icdf_pkg
// Shared types and constants for the inverse-cdf table sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package icdf_pkg;

    localparam int WEIGHT_W = 32;
    localparam int ENERGY_W = 24;
    localparam int PROD_W   = WEIGHT_W + ENERGY_W;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

    localparam logic [1:0] MODE_FIXED    = 2'd0;
    localparam logic [1:0] MODE_DISCRETE = 2'd1;
    localparam logic [1:0] MODE_INTERP   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_ENERGY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_WEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH    = 3'd4;

    localparam logic [1:0]          RST_MODE         = MODE_FIXED;
    localparam logic [ENERGY_W-1:0] RST_FIXED_ENERGY = 24'd1000000;
    localparam logic [10:0]         RST_ENTRY_COUNT  = 11'd1;
    localparam logic [WEIGHT_W-1:0] RST_TOTAL_WEIGHT = 32'd0;
    localparam logic [ENERGY_W-1:0] RST_BIN_WIDTH    = 24'd100000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCALE,
        S_DSCAN,
        S_ICHK0,
        S_ICHKHI,
        S_ISRCH,
        S_IMID,
        S_IMUL,
        S_IDIV,
        S_FIN
    } t_state;

endpackage

`default_nettype wire

// ----- sv/icdf_div.sv -----
// ----------------------------------------------------------------------------
// icdf_div
// Serial restoring divider, one quotient bit per cycle. The quotient is known
// to fit in the energy width, so the high part of the dividend starts as the
// partial remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module icdf_div
    import icdf_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [PROD_W-1:0]   i_dividend,
    input  wire logic [WEIGHT_W-1:0] i_divisor,
    output logic                     o_done,
    output logic [ENERGY_W-1:0]      o_quotient
);

    localparam int CNT_W = $clog2(ENERGY_W + 1);

    logic [WEIGHT_W-1:0] r_rem;
    logic [WEIGHT_W-1:0] r_den;
    logic [ENERGY_W-1:0] r_dq;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [WEIGHT_W:0]   trial;
    logic                fits;

    assign trial = {r_rem, r_dq[ENERGY_W-1]};
    assign fits  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ENERGY_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[PROD_W-1:ENERGY_W];
            r_dq  <= i_dividend[ENERGY_W-1:0];
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? WEIGHT_W'(trial - {1'b0, r_den}) : trial[WEIGHT_W-1:0];
            r_dq  <= {r_dq[ENERGY_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dq;

endmodule

`default_nettype wire

// ----- sv/inverse_cdf_table_sampler.sv -----
// ----------------------------------------------------------------------------
// inverse_cdf_table_sampler
// Draws an energy from a loaded cumulative weight table: fixed, discrete
// level lookup, or binary search with linear interpolation.
// ----------------------------------------------------------------------------
// load transaction: taken in idle, the next transaction can follow right after
// sample: input stalls until the result is parked, next accept in the cycle after
// accept to result register: fixed mode goes straight to the result, discrete scans
// with one read per cycle, interpolated runs a binary search on the single read port
//   and then the divider; a stalled result holds the core
// reset clears control and config registers; table contents stay undefined
`default_nettype none

module inverse_cdf_table_sampler
    import icdf_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]      i_cfg_data,

    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_func,
    input  wire logic [9:0]            i_entry_index,
    input  wire logic [WEIGHT_W-1:0]   i_weight_bound,
    input  wire logic [ENERGY_W-1:0]   i_energy_value,
    input  wire logic [WEIGHT_W-1:0]   i_uniform_value,

    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [ENERGY_W-1:0]        o_sampled_energy,
    output logic                       o_not_found
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // config registers
    logic [1:0]          r_mode;
    logic [ENERGY_W-1:0] r_fixed_energy;
    logic [10:0]         r_entry_count;
    logic [WEIGHT_W-1:0] r_total_weight;
    logic [ENERGY_W-1:0] r_bin_width;

    t_state r_state, n_state;

    logic [PROD_W-1:0]   mem [TABLE_DEPTH];
    logic [PROD_W-1:0]   r_rd_data;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [WEIGHT_W-1:0] rd_bound;
    logic [ENERGY_W-1:0] rd_energy;

    logic                in_acc;
    logic [31:0]         idx_ext;
    logic                idx_ok;
    logic [31:0]         ec_ext;
    logic [CW-1:0]       n_used;

    logic [WEIGHT_W-1:0] r_u;
    logic [WEIGHT_W-1:0] r_s;
    logic [63:0]         scale_prod;
    logic [CW-1:0]       r_n;
    logic [AW-1:0]       last_idx;

    logic [AW-1:0]       r_addr;
    logic                r_more;
    logic                r_pend;
    logic                r_pend_last;
    logic                d_hit;

    logic [AW-1:0]       r_lo;
    logic [AW-1:0]       r_hi;
    logic [WEIGHT_W-1:0] r_blo;
    logic [WEIGHT_W-1:0] r_bhi;
    logic [ENERGY_W-1:0] r_elo;
    logic [AW:0]         mid_sum;
    logic [AW-1:0]       mid;
    logic [AW-1:0]       span;

    logic [PROD_W-1:0]   div_dividend;
    logic [WEIGHT_W-1:0] div_divisor;
    logic [ENERGY_W-1:0] div_q;
    logic                div_start;
    logic                div_done;
    logic [ENERGY_W:0]   interp_sum;

    logic [ENERGY_W-1:0] r_res_e;
    logic                r_res_nf;
    logic                slot_free;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    assign idx_ext = 32'(i_entry_index);
    assign idx_ok  = (idx_ext < 32'(TABLE_DEPTH));

    assign ec_ext = 32'(r_entry_count);
    always_comb begin
        if (ec_ext == 32'd0) begin
            n_used = CW'(1);
        end else if (ec_ext > 32'(TABLE_DEPTH)) begin
            n_used = CW'(TABLE_DEPTH);
        end else begin
            n_used = CW'(ec_ext);
        end
    end

    assign scale_prod = r_u * r_total_weight;
    assign last_idx   = AW'(r_n - 1'b1);
    assign rd_bound   = r_rd_data[PROD_W-1:ENERGY_W];
    assign rd_energy  = r_rd_data[ENERGY_W-1:0];
    assign d_hit      = r_pend && (rd_bound > r_s);
    assign mid_sum    = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid        = mid_sum[AW:1];
    assign span       = r_hi - r_lo;
    assign slot_free  = !o_out_valid || !i_out_stall;

    assign div_dividend = r_bin_width * (r_s - r_blo);
    assign div_divisor  = r_bhi - r_blo;
    assign interp_sum   = {1'b0, r_elo} + {1'b0, div_q};

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= RST_MODE;
            r_fixed_energy <= RST_FIXED_ENERGY;
            r_entry_count  <= RST_ENTRY_COUNT;
            r_total_weight <= RST_TOTAL_WEIGHT;
            r_bin_width    <= RST_BIN_WIDTH;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_MODE:         r_mode         <= i_cfg_data[1:0];
                CFG_FIXED_ENERGY: r_fixed_energy <= i_cfg_data[ENERGY_W-1:0];
                CFG_ENTRY_COUNT:  r_entry_count  <= i_cfg_data[10:0];
                CFG_TOTAL_WEIGHT: r_total_weight <= i_cfg_data[WEIGHT_W-1:0];
                CFG_BIN_WIDTH:    r_bin_width    <= i_cfg_data[ENERGY_W-1:0];
                default: ;
            endcase
        end
    end

    // table memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (in_acc && !i_func && idx_ok) begin
            mem[idx_ext[AW-1:0]] <= {i_weight_bound, i_energy_value};
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_func) n_state = S_SCALE;
            end
            S_SCALE: begin
                if (r_mode == MODE_DISCRETE) n_state = S_DSCAN;
                else if (r_mode == MODE_INTERP) n_state = S_ICHK0;
                else n_state = S_FIN;
            end
            S_DSCAN: begin
                if (d_hit || (r_pend && r_pend_last)) n_state = S_FIN;
            end
            S_ICHK0: begin
                n_state = (r_s <= rd_bound) ? S_FIN : S_ICHKHI;
            end
            S_ICHKHI: begin
                n_state = (rd_bound < r_s) ? S_FIN : S_ISRCH;
            end
            S_ISRCH: begin
                n_state = (span > AW'(1)) ? S_IMID : S_IMUL;
            end
            S_IMID:  n_state = S_ISRCH;
            S_IMUL:  n_state = S_IDIV;
            S_IDIV: begin
                if (div_done) n_state = S_FIN;
            end
            S_FIN: begin
                if (slot_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs: table reads and divider start
    always_comb begin
        rd_en     = 1'b0;
        rd_addr   = '0;
        div_start = 1'b0;
        unique case (r_state)
            S_SCALE: begin
                rd_en = (r_mode == MODE_INTERP);
            end
            S_DSCAN: begin
                rd_en   = r_more;
                rd_addr = r_addr;
            end
            S_ICHK0: begin
                rd_en   = 1'b1;
                rd_addr = last_idx;
            end
            S_ISRCH: begin
                rd_en   = (span > AW'(1));
                rd_addr = mid;
            end
            S_IMUL: begin
                div_start = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_more <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) r_u <= i_uniform_value;
                end
                S_SCALE: begin
                    r_s      <= scale_prod[63:32];
                    r_n      <= n_used;
                    r_addr   <= '0;
                    r_more   <= 1'b1;
                    r_pend   <= 1'b0;
                    r_res_e  <= r_fixed_energy;
                    r_res_nf <= 1'b0;
                end
                S_DSCAN: begin
                    // reads run one ahead of the compare
                    if (r_more) begin
                        r_addr <= r_addr + 1'b1;
                        r_more <= (r_addr != last_idx);
                    end
                    r_pend      <= r_more;
                    r_pend_last <= (r_addr == last_idx);
                    r_res_e     <= d_hit ? rd_energy : '0;
                    r_res_nf    <= !d_hit;
                end
                S_ICHK0: begin
                    r_lo    <= '0;
                    r_blo   <= rd_bound;
                    r_elo   <= rd_energy;
                    r_res_e <= rd_energy;
                end
                S_ICHKHI: begin
                    r_hi    <= last_idx;
                    r_bhi   <= rd_bound;
                    r_res_e <= rd_energy;
                end
                S_IMID: begin
                    if (rd_bound >= r_s) begin
                        r_hi  <= mid;
                        r_bhi <= rd_bound;
                    end else begin
                        r_lo  <= mid;
                        r_blo <= rd_bound;
                        r_elo <= rd_energy;
                    end
                end
                S_IDIV: begin
                    r_res_e <= interp_sum[ENERGY_W] ? ENERGY_MAX
                                                    : interp_sum[ENERGY_W-1:0];
                end
                default: ;
            endcase
            // mid is latched alongside the read for the compare cycle
            if (r_state == S_ISRCH) begin
                r_addr <= mid;
            end
        end
    end

    // result register, frees the core as soon as the result is parked
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (r_state == S_FIN && slot_free) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && slot_free) begin
            o_sampled_energy <= r_res_e;
            o_not_found      <= r_res_nf;
        end
    end

    icdf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    a_nf_discrete_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_res_nf) |-> (r_mode == MODE_DISCRETE))
        else $error("not_found raised outside discrete mode");

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_IDIV))
        else $error("divider finished outside its wait state");

    a_search_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ISRCH) |-> (r_hi >= r_lo))
        else $error("search bracket inverted");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DSCAN && rd_en) |-> (CW'(r_addr) < r_n))
        else $error("discrete scan read beyond entries in use");

    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DSCAN || r_state == S_IDIV) |=> !$past(in_acc))
        else $error("transaction accepted while a sample was in progress");

endmodule

`default_nettype wire

// ----- test/inverse_cdf_table_sampler_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverse_cdf_table_sampler_checker
// Watches the config port and both channels of the sampler, keeps its own
// copy of the table and registers, predicts each drawn energy and compares
// every output transaction against the oldest prediction.
// ----------------------------------------------------------------------------

module inverse_cdf_table_sampler_checker
    import icdf_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_stall,
    input  wire logic                 i_func,
    input  wire logic [9:0]           i_entry_index,
    input  wire logic [WEIGHT_W-1:0]  i_weight_bound,
    input  wire logic [ENERGY_W-1:0]  i_energy_value,
    input  wire logic [WEIGHT_W-1:0]  i_uniform_value,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_stall,
    input  wire logic [ENERGY_W-1:0]  i_sampled_energy,
    input  wire logic                 i_not_found,
    output int                        o_errors,
    output int                        o_pending
);

    localparam int DEPTH = 1024;

    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic                miss;
    } t_draw;

    logic [WEIGHT_W-1:0] bound_tab [DEPTH];
    logic [ENERGY_W-1:0] energy_tab [DEPTH];

    logic [1:0]          mode_r;
    logic [ENERGY_W-1:0] fixed_r;
    logic [10:0]         count_r;
    logic [WEIGHT_W-1:0] total_r;
    logic [ENERGY_W-1:0] width_r;

    t_draw draw_q [$];

    initial o_errors = 0;
    assign o_pending = draw_q.size();

    function automatic t_draw predict_draw(logic [WEIGHT_W-1:0] u);
        logic [63:0] prod;
        logic [63:0] acc;
        logic [WEIGHT_W-1:0] s;
        int n;
        int lo;
        int hi;
        int mid;
        t_draw d;
        prod = {32'd0, u} * {32'd0, total_r};
        s = prod[63:32];
        n = (count_r == 0) ? 1 : ((count_r > DEPTH) ? DEPTH : int'(count_r));
        d.miss = 1'b0;
        d.energy = fixed_r;
        if (mode_r == MODE_DISCRETE) begin
            d.miss = 1'b1;
            d.energy = '0;
            for (int i = 0; i < n; i++) begin
                if (d.miss && bound_tab[i] > s) begin
                    d.miss = 1'b0;
                    d.energy = energy_tab[i];
                end
            end
        end else if (mode_r == MODE_INTERP) begin
            lo = 0;
            hi = n - 1;
            if (s <= bound_tab[0]) begin
                d.energy = energy_tab[0];
            end else if (bound_tab[hi] < s) begin
                d.energy = energy_tab[hi];
            end else begin
                while (hi - lo > 1) begin
                    mid = (lo + hi) / 2;
                    if (bound_tab[mid] >= s) hi = mid;
                    else lo = mid;
                end
                acc = {40'd0, energy_tab[lo]};
                if (bound_tab[hi] != bound_tab[lo])
                    acc = acc + ({40'd0, width_r} * {32'd0, s - bound_tab[lo]})
                          / {32'd0, bound_tab[hi] - bound_tab[lo]};
                d.energy = (acc > {40'd0, ENERGY_MAX}) ? ENERGY_MAX : acc[ENERGY_W-1:0];
            end
        end
        return d;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s mismatch: got %0d expected %0d", $time, what, got, want);
        o_errors = o_errors + 1;
    endtask

    always @(posedge i_clk) begin
        t_draw want;
        if (!i_rst_n) begin
            mode_r  = RST_MODE;
            fixed_r = RST_FIXED_ENERGY;
            count_r = RST_ENTRY_COUNT;
            total_r = RST_TOTAL_WEIGHT;
            width_r = RST_BIN_WIDTH;
            draw_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (draw_q.size() == 0) begin
                    report_mismatch("unexpected result", 32'(i_sampled_energy), '0);
                end else begin
                    want = draw_q.pop_front();
                    if (i_sampled_energy !== want.energy)
                        report_mismatch("sampled_energy", 32'(i_sampled_energy),
                                        32'(want.energy));
                    if (i_not_found !== want.miss)
                        report_mismatch("not_found", 32'(i_not_found), 32'(want.miss));
                end
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_MODE:         mode_r  = i_cfg_data[1:0];
                    CFG_FIXED_ENERGY: fixed_r = i_cfg_data[ENERGY_W-1:0];
                    CFG_ENTRY_COUNT:  count_r = i_cfg_data[10:0];
                    CFG_TOTAL_WEIGHT: total_r = i_cfg_data;
                    CFG_BIN_WIDTH:    width_r = i_cfg_data[ENERGY_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_func) begin
                    draw_q.insert(draw_q.size(), predict_draw(i_uniform_value));
                end else begin
                    bound_tab[i_entry_index]  = i_weight_bound;
                    energy_tab[i_entry_index] = i_energy_value;
                end
            end
        end
    end

endmodule

// ----- test/inverse_cdf_table_sampler_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverse_cdf_table_sampler_tb
// Loads cumulative tables and draws samples in every mode over many register
// settings and idle/stall profiles; a checker module scores the results.
// ----------------------------------------------------------------------------

module inverse_cdf_table_sampler_tb
    import icdf_pkg::*;
();

    localparam int DEPTH = 1024;
    localparam int SETTLE = 1100;
    localparam int FUNC_LOAD = 0;
    localparam int FUNC_DRAW = 1;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_func;
    logic [9:0]           i_entry_index;
    logic [WEIGHT_W-1:0]  i_weight_bound;
    logic [ENERGY_W-1:0]  i_energy_value;
    logic [WEIGHT_W-1:0]  i_uniform_value;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [ENERGY_W-1:0]  o_sampled_energy;
    logic                 o_not_found;

    int errors;
    int pending;
    int idle_pct;
    int stall_pct;
    int item_cnt;
    int phase_cnt;
    logic [WEIGHT_W-1:0] last_bound;

    inverse_cdf_table_sampler DUT (.*);

    inverse_cdf_table_sampler_checker u_checker (
        .i_in_stall      (o_in_stall),
        .i_out_valid     (o_out_valid),
        .i_sampled_energy(o_sampled_energy),
        .i_not_found     (o_not_found),
        .o_errors        (errors),
        .o_pending       (pending),
        .*
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) i_out_stall <= ($urandom_range(99) < stall_pct);

    initial begin
        #30_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_item(int fn, logic [9:0] idx, logic [31:0] wb,
                             logic [23:0] ev, logic [31:0] u);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_func          <= fn[0];
        i_entry_index   <= idx;
        i_weight_bound  <= wb;
        i_energy_value  <= ev;
        i_uniform_value <= u;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        item_cnt++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
    endtask

    // wait for the block to drain before touching the registers
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_uniform();
        case ($urandom_range(7))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [23:0] pick_energy();
        return ($urandom_range(7) == 0) ? 24'(ENERGY_MAX - $urandom_range(3))
                                        : 24'($urandom);
    endfunction

    // loads entries 0..n-1, sorted bounds unless scrambled
    task automatic load_table(int n, bit scrambled);
        logic [31:0] b;
        logic [31:0] step;
        b = $urandom_range(3) == 0 ? 32'd0 : $urandom_range(1000);
        step = (32'hFFFF_FFFF / n) >> $urandom_range(8);
        for (int i = 0; i < n; i++) begin
            if (scrambled) b = $urandom;
            else if (i > 0) b = b + (($urandom_range(5) == 0) ? 32'd0 : $urandom_range(step));
            send_item(FUNC_LOAD, i[9:0], b, pick_energy(), $urandom);
        end
        last_bound = b;
    endtask

    task automatic run_phase(logic [1:0] mode, logic [23:0] fe, logic [10:0] cnt,
                             int tw_sel, logic [23:0] bw, int draws, bit reload,
                             bit scrambled);
        int n;
        logic [31:0] tw;
        n = (cnt == 0) ? 1 : ((cnt > DEPTH) ? DEPTH : int'(cnt));
        case (phase_cnt % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 55; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 55; end
            default: begin idle_pct = 37; stall_pct = 37; end
        endcase
        phase_cnt++;
        if (reload) load_table(n, scrambled);
        drain();
        case (tw_sel)
            0: tw = last_bound;
            1: tw = $urandom;
            2: tw = 32'd0;
            default: tw = 32'hFFFF_FFFF;
        endcase
        write_reg(CFG_MODE, {30'd0, mode});
        write_reg(CFG_FIXED_ENERGY, {8'd0, fe});
        write_reg(CFG_ENTRY_COUNT, {21'd0, cnt});
        write_reg(CFG_TOTAL_WEIGHT, tw);
        write_reg(CFG_BIN_WIDTH, {8'd0, bw});
        i_cfg_wr_en <= 1'b0;
        for (int k = 0; k < draws; k++) begin
            // occasional rewrite of a live entry, keeps the table fully written
            if (reload && $urandom_range(99) < 12)
                send_item(FUNC_LOAD, 10'($urandom_range(n - 1)), $urandom, pick_energy(), 0);
            else
                send_item(FUNC_DRAW, 10'($urandom), $urandom, 24'($urandom), pick_uniform());
        end
        drain();
    endtask

    initial begin
        logic [1:0] m;
        logic [10:0] c;
        i_rst_n         <= 1'b0;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_index     <= '0;
        i_cfg_data      <= '0;
        i_in_valid      <= 1'b0;
        i_func          <= 1'b0;
        i_entry_index   <= '0;
        i_weight_bound  <= '0;
        i_energy_value  <= '0;
        i_uniform_value <= '0;
        idle_pct = 0;
        stall_pct = 0;
        item_cnt = 0;
        phase_cnt = 0;
        last_bound = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // register defaults: fixed mode, zero total weight
        send_item(FUNC_DRAW, 10'h3FF, 32'hFFFF_FFFF, ENERGY_MAX, 32'd0);
        send_item(FUNC_DRAW, 10'h000, 32'd0, 24'd0, 32'hFFFF_FFFF);
        drain();

        // unused mode acts as fixed, zero count acts as one
        run_phase(2'd3, ENERGY_MAX, 11'd0, 3, 24'd0, 2, 1'b1, 1'b0);
        run_phase(MODE_FIXED, 24'd0, 11'd1, 1, ENERGY_MAX, 2, 1'b0, 1'b0);
        // discrete: hits, misses with oversized total weight
        run_phase(MODE_DISCRETE, 24'd5, 11'd4, 0, 24'd0, 4, 1'b1, 1'b0);
        run_phase(MODE_DISCRETE, 24'd5, 11'd4, 3, 24'd0, 4, 1'b0, 1'b0);
        // interpolated: below first bound, above last, saturation
        run_phase(MODE_INTERP, 24'd0, 11'd1, 3, ENERGY_MAX, 3, 1'b1, 1'b0);
        run_phase(MODE_INTERP, 24'd0, 11'd8, 0, ENERGY_MAX, 4, 1'b1, 1'b0);
        run_phase(MODE_INTERP, 24'd0, 11'd8, 3, 24'd0, 3, 1'b0, 1'b0);

        // full table, count saturated above depth
        run_phase(MODE_INTERP, 24'd1, 11'd2047, 0, 24'd100000, 8, 1'b1, 1'b0);
        run_phase(MODE_DISCRETE, 24'd1, 11'd1024, 0, 24'd0, 4, 1'b0, 1'b0);

        while (item_cnt < 1450) begin
            m = $urandom_range(9) == 0 ? 2'd3 : 2'($urandom_range(2));
            c = ($urandom_range(9) == 0) ? 11'($urandom_range(64)) : 11'($urandom_range(16));
            run_phase(m, 24'($urandom), c,
                      ($urandom_range(9) < 6) ? 0 : $urandom_range(3),
                      ($urandom_range(9) == 0) ? ENERGY_MAX : 24'($urandom_range(200000)),
                      $urandom_range(10, 40), 1'b1, $urandom_range(9) == 0);
        end

        if (errors == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
